// ===== rtl/core/rm2q_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion converter.
// No dependencies; imported by the core and by its port checker.
package rm2q_pkg;

	localparam int ELEMENT_WIDTH_DEF = 16;
	localparam int FRACTION_BITS_DEF = 14;

	typedef enum logic [1:0] {
		PIVOT_TRACE = 2'd0,
		PIVOT_X     = 2'd1,
		PIVOT_Y     = 2'd2,
		PIVOT_Z     = 2'd3
	} pivot_t;

endpackage

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
// Pipelined rotation matrix to unit quaternion converter, streaming ports.
// Depends on rm2q_pkg (pivot codes, default widths).
//
// Accepts one 3x3 matrix per clock while the output is not stalled and
// returns one quaternion per matrix, in order. SW, the number of root bits,
// is half the radicand width rounded up (SW = 16 at the default Q1.14).
// The first stage picks the pivot (trace, or the largest diagonal
// element) and forms the exact unscaled components; then one stage per root
// bit takes the square root of the pivot sum; then four dividers, one
// quotient bit per stage, scale each component by 0.5/sqrt with rounding to
// nearest (ties away from zero); the last stage saturates. Every stage has
// its own valid bit and holds only when the stage after it is full and
// stalled, so bubbles close up and tready stays high while the pipe has room.
// pivot_case reports the branch taken; bad_input flags a pivot sum that is
// not positive, in which case the four components read zero.
module rotation_matrix_to_quaternion
	import rm2q_pkg::*;
#(
	parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	localparam int IDW = ((9 * ELEMENT_WIDTH + 7) / 8) * 8,
	localparam int ODW = ((4 * ELEMENT_WIDTH + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	// e11, e12, e13, e21, e22, e23, e31, e32, e33 from the lowest bit, zero pad
	input  logic [IDW-1:0] s_tdata,
	output logic           m_tvalid,
	input  logic           m_tready,
	// quat_x, quat_y, quat_z, quat_w from the lowest bit, zero pad
	output logic [ODW-1:0] m_tdata,
	// pivot_case [1:0], bad_input [2]
	output logic [2:0]     m_tuser
);

	localparam int W   = ELEMENT_WIDTH;
	localparam int F   = FRACTION_BITS;
	// signed width for the pivot sum and unscaled components
	localparam int VW  = ((W > F + 1) ? W : F + 1) + 3;
	localparam int MW  = VW;
	localparam int RW0 = VW - 1 + F;
	localparam int RW  = RW0 + (RW0 % 2);
	localparam int SW  = RW / 2;
	localparam int DW  = SW + 1;
	localparam int NW  = MW + F + 1;
	localparam int QW  = W + 1;
	localparam int HW  = NW - QW;
	localparam int CW  = (HW > DW) ? HW : DW;
	// stage map: 0 pivot, 1 radicand, 2..SW+1 root, SW+2 range, then QW divide, output
	localparam int SQ0 = 1;
	localparam int DV0 = SW + 2;
	localparam int OST = SW + QW + 3;
	localparam int L   = OST + 1;

	typedef struct packed {
		pivot_t              pc;
		logic                bad;
		logic [3:0]          neg;
		logic [3:0][MW-1:0]  mag;
	} sq_meta_t;

	typedef struct packed {
		pivot_t              pc;
		logic                bad;
		logic [3:0]          neg;
		logic [3:0]          ovf;
		logic [DW-1:0]       d;
	} dv_meta_t;

	// ---------------------------------------------------------------- flow control
	logic [L-1:0] vld_s;
	logic [L:0]   ce;

	// A stage loads when it is empty or the stage after it moves.
	always_comb begin
		ce[L] = m_tready;
		for (int i = L - 1; i >= 0; i--) begin
			ce[i] = !vld_s[i] || ce[i+1];
		end
	end

	assign s_tready = ce[0];
	assign m_tvalid = vld_s[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int i = 0; i < L; i++) begin
				if (ce[i]) begin
					vld_s[i] <= (i == 0) ? s_tvalid : vld_s[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	// ---------------------------------------------------------------- stage 1: pivot
	logic signed [VW-1:0] a11, a12, a13, a21, a22, a23, a31, a32, a33;
	logic signed [VW-1:0] one_v, tr, v_n;
	logic signed [VW-1:0] c_n [4];
	pivot_t               pc_n;

	assign a11 = VW'($signed(s_tdata[0*W +: W]));
	assign a12 = VW'($signed(s_tdata[1*W +: W]));
	assign a13 = VW'($signed(s_tdata[2*W +: W]));
	assign a21 = VW'($signed(s_tdata[3*W +: W]));
	assign a22 = VW'($signed(s_tdata[4*W +: W]));
	assign a23 = VW'($signed(s_tdata[5*W +: W]));
	assign a31 = VW'($signed(s_tdata[6*W +: W]));
	assign a32 = VW'($signed(s_tdata[7*W +: W]));
	assign a33 = VW'($signed(s_tdata[8*W +: W]));
	assign one_v = VW'(1) <<< F;
	assign tr = a11 + a22 + a33;

	always_comb begin
		if (tr > 0) begin
			pc_n = PIVOT_TRACE;
		end else if (a11 > a22 && a11 > a33) begin
			pc_n = PIVOT_X;
		end else if (a22 > a33) begin
			pc_n = PIVOT_Y;
		end else begin
			pc_n = PIVOT_Z;
		end
		case (pc_n)
			PIVOT_TRACE: begin
				v_n = tr + one_v;
				c_n[0] = a32 - a23; c_n[1] = a13 - a31; c_n[2] = a21 - a12; c_n[3] = v_n;
			end
			PIVOT_X: begin
				v_n = one_v + a11 - a22 - a33;
				c_n[0] = v_n; c_n[1] = a12 + a21; c_n[2] = a13 + a31; c_n[3] = a32 - a23;
			end
			PIVOT_Y: begin
				v_n = one_v + a22 - a11 - a33;
				c_n[0] = a12 + a21; c_n[1] = v_n; c_n[2] = a23 + a32; c_n[3] = a13 - a31;
			end
			default: begin
				v_n = one_v + a33 - a11 - a22;
				c_n[0] = a13 + a31; c_n[1] = a23 + a32; c_n[2] = v_n; c_n[3] = a21 - a12;
			end
		endcase
	end

	pivot_t               pc_s1;
	logic signed [VW-1:0] v_s1;
	logic signed [VW-1:0] c_s1 [4];

	always_ff @(posedge clk) begin
		if (ce[0]) begin
			pc_s1 <= pc_n;
			v_s1  <= v_n;
			for (int k = 0; k < 4; k++) begin
				c_s1[k] <= c_n[k];
			end
		end
	end

	// ---------------------------------------------------------------- square root
	sq_meta_t      sq_meta_s [SW+1];
	logic [RW-1:0] sq_rad_s  [SW+1];
	logic [SW:0]   sq_rem_s  [SW+1];
	logic [SW-1:0] sq_root_s [SW+1];

	// Split components into sign and magnitude, clear the radicand when bad.
	always_ff @(posedge clk) begin
		if (ce[SQ0]) begin
			sq_meta_s[0].pc  <= pc_s1;
			sq_meta_s[0].bad <= (v_s1 <= 0);
			for (int k = 0; k < 4; k++) begin
				sq_meta_s[0].neg[k] <= c_s1[k][VW-1];
				sq_meta_s[0].mag[k] <= c_s1[k][VW-1] ? MW'(-c_s1[k]) : MW'(c_s1[k]);
			end
			sq_rad_s[0]  <= (v_s1 <= 0) ? '0 : (RW'(v_s1[VW-2:0]) << F);
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < SW; j++) begin : g_sqrt
		logic [SW+2:0] cur, trial;
		logic          take;

		assign cur   = {sq_rem_s[j], sq_rad_s[j][RW-1:RW-2]};
		assign trial = (SW + 3)'({sq_root_s[j], 2'b01});
		assign take  = (cur >= trial);

		// One root bit per stage: subtract the trial square when it fits.
		always_ff @(posedge clk) begin
			if (ce[SQ0 + j + 1]) begin
				sq_meta_s[j+1] <= sq_meta_s[j];
				sq_rad_s[j+1]  <= sq_rad_s[j] << 2;
				sq_rem_s[j+1]  <= take ? (SW + 1)'(cur - trial) : cur[SW:0];
				sq_root_s[j+1] <= {sq_root_s[j][SW-2:0], take};
			end
		end
	end

	// ---------------------------------------------------------------- range check
	dv_meta_t            dv_meta_s [QW+1];
	logic [3:0][QW-1:0]  dv_lo_s   [QW+1];
	logic [3:0][DW-1:0]  dv_rem_s  [QW+1];
	logic [3:0][QW-1:0]  dv_quo_s  [QW+1];

	logic [DW-1:0]      d_n;
	logic [3:0][NW-1:0] num_n;
	logic [3:0]         ovf_n;

	assign d_n = {sq_root_s[SW], 1'b0};

	// Numerator is |c| * 2^F + S; flag quotients of 2^QW or more up front.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			num_n[k] = (NW'(sq_meta_s[SW].mag[k]) << F) + NW'(sq_root_s[SW]);
			ovf_n[k] = (CW'(num_n[k][NW-1:QW]) >= CW'(d_n));
		end
	end

	always_ff @(posedge clk) begin
		if (ce[DV0]) begin
			dv_meta_s[0].pc  <= sq_meta_s[SW].pc;
			dv_meta_s[0].bad <= sq_meta_s[SW].bad;
			dv_meta_s[0].neg <= sq_meta_s[SW].neg;
			dv_meta_s[0].ovf <= ovf_n;
			dv_meta_s[0].d   <= d_n;
			for (int k = 0; k < 4; k++) begin
				dv_lo_s[0][k]  <= num_n[k][QW-1:0];
				dv_rem_s[0][k] <= ovf_n[k] ? '0 : DW'(num_n[k][NW-1:QW]);
				dv_quo_s[0][k] <= '0;
			end
		end
	end

	// ---------------------------------------------------------------- divide
	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [3:0][DW:0] part;
		logic [3:0]       fit;

		always_comb begin
			for (int k = 0; k < 4; k++) begin
				part[k] = {dv_rem_s[j][k], dv_lo_s[j][k][QW-1]};
				fit[k]  = (part[k] >= {1'b0, dv_meta_s[j].d});
			end
		end

		// One quotient bit per stage for each of the four components.
		always_ff @(posedge clk) begin
			if (ce[DV0 + j + 1]) begin
				dv_meta_s[j+1] <= dv_meta_s[j];
				for (int k = 0; k < 4; k++) begin
					dv_lo_s[j+1][k]  <= dv_lo_s[j][k] << 1;
					dv_rem_s[j+1][k] <= fit[k] ? DW'(part[k] - {1'b0, dv_meta_s[j].d})
						: DW'(part[k]);
					dv_quo_s[j+1][k] <= {dv_quo_s[j][k][QW-2:0], fit[k]};
				end
			end
		end
	end

	// ---------------------------------------------------------------- saturate, output
	localparam logic [QW-1:0] POS_LIM = QW'((1 << (W - 1)) - 1);
	localparam logic [QW-1:0] NEG_LIM = QW'(1) << (W - 1);

	logic [3:0][W-1:0] q_n;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (dv_meta_s[QW].bad) begin
				q_n[k] = '0;
			end else if (dv_meta_s[QW].neg[k]) begin
				if (dv_meta_s[QW].ovf[k] || dv_quo_s[QW][k] > NEG_LIM) begin
					q_n[k] = W'(-NEG_LIM);
				end else begin
					q_n[k] = W'(-dv_quo_s[QW][k]);
				end
			end else begin
				if (dv_meta_s[QW].ovf[k] || dv_quo_s[QW][k] > POS_LIM) begin
					q_n[k] = W'(POS_LIM);
				end else begin
					q_n[k] = W'(dv_quo_s[QW][k]);
				end
			end
		end
	end

	logic [3:0][W-1:0] quat_s;
	pivot_t            pc_out_s;
	logic              bad_out_s;

	always_ff @(posedge clk) begin
		if (ce[OST]) begin
			quat_s    <= q_n;
			pc_out_s  <= dv_meta_s[QW].pc;
			bad_out_s <= dv_meta_s[QW].bad;
		end
	end

	assign m_tdata = ODW'(quat_s);
	assign m_tuser = {bad_out_s, pc_out_s};

endmodule

// ===== rtl/core/rm2q_checker.sv =====
// Port-level checks for rotation_matrix_to_quaternion, bound to the top level.
// Depends on rm2q_pkg for the pivot codes.
module rm2q_checker
	import rm2q_pkg::*;
#(
	parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
	parameter int ODW = ((4 * ELEMENT_WIDTH + 7) / 8) * 8
) (
	input logic           clk,
	input logic           arst_n,
	input logic           m_tvalid,
	input logic           m_tready,
	input logic [ODW-1:0] m_tdata,
	input logic [2:0]     m_tuser
);

	localparam int W = ELEMENT_WIDTH;

	// Hold a stalled result transaction.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tdata[4*W-1:0] == '0)
		else $error("bad input with nonzero components");

	a_trace_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == PIVOT_TRACE |-> !m_tuser[2])
		else $error("trace pivot flagged bad");

	a_trace_w: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == PIVOT_TRACE |-> !m_tdata[4*W-1])
		else $error("trace pivot with negative w");

endmodule

bind rotation_matrix_to_quaternion rm2q_checker #(
	.ELEMENT_WIDTH(ELEMENT_WIDTH)
) u_rm2q_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
